@@ rtl/clcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and tables of the character display command sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

    // Request codes
    localparam logic [2:0] REQ_INIT      = 3'd0;
    localparam logic [2:0] REQ_CLEAR     = 3'd1;
    localparam logic [2:0] REQ_SETCUR    = 3'd2;
    localparam logic [2:0] REQ_PRINT     = 3'd3;
    localparam logic [2:0] REQ_BACKLIGHT = 3'd4;

    // Queued operation codes
    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_BYTE   = 2'd1;
    localparam logic [1:0] OP_SINGLE = 2'd2;
    localparam logic [1:0] OP_ERROR  = 2'd3;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_DDRAM    = 8'h80;
    localparam logic [2:0] MAX_ROW      = 3'd3;
    localparam logic [4:0] MAX_COLUMN   = 5'd19;

    // Init runs as a string of nibbles, three writes each
    localparam logic [3:0] INIT_LAST_NIB  = 4'd13;
    localparam logic [3:0] INIT_CLEAR_NIB = 4'd9;
    localparam logic [1:0] PH_LAST        = 2'd2;
    localparam logic [1:0] PAUSE_CLEAR_MS = 2'd2;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam logic [7:0] DEV_ADDR_RESET = 8'd78;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       rs;
        logic       clr;
        logic       bl;
    } t_cmd;

    function automatic logic [7:0] row_offset(input logic [1:0] row);
        case (row)
            2'd0:    row_offset = 8'h00;
            2'd1:    row_offset = 8'h40;
            2'd2:    row_offset = 8'h14;
            default: row_offset = 8'h54;
        endcase
    endfunction

    // Reset nibbles, then the set-up bytes split high nibble first
    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        case (idx)
            4'd0, 4'd1, 4'd2: init_nibble = 4'h3;
            4'd3, 4'd4:       init_nibble = 4'h2;
            4'd5, 4'd7:       init_nibble = 4'h8;
            4'd9:             init_nibble = 4'h1;
            4'd11:            init_nibble = 4'h6;
            4'd13:            init_nibble = 4'hC;
            default:          init_nibble = 4'h0;
        endcase
    endfunction

    function automatic logic [5:0] init_pause(input logic [3:0] idx);
        case (idx)
            4'd0:       init_pause = 6'd50;
            4'd1:       init_pause = 6'd5;
            4'd2, 4'd3: init_pause = 6'd1;
            default:    init_pause = 6'd0;
        endcase
    endfunction

endpackage

@@ rtl/char_lcd_expander_command_sequencer_unit.sv @@
`timescale 1ns / 1ps
// Latency: the first write of a command passes through the queue, then the output register.
// Throughput: one expander write per cycle while the output is not stalled; a clear, cursor
// or print command gives 6 writes, init 42, backlight and rejected commands 1.
// Reset: synchronous, active low; display not initialized, backlight on, address 78.
// ----------------------------------------------------------------------------
// char_lcd_expander_command_sequencer_unit
// Command sequencer for a 4-bit character display behind an I/O expander.
// ----------------------------------------------------------------------------
module char_lcd_expander_command_sequencer_unit
    import clcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_char_code,
    input  logic [2:0] i_row,
    input  logic [4:0] i_column,
    input  logic       i_backlight_enable,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_device_address,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_expander_byte,
    output logic [7:0] o_bus_address,
    output logic [5:0] o_pause_before_ms,
    output logic [1:0] o_pause_after_ms,
    output logic       o_error,
    output logic       o_last
);

    logic [7:0] r_dev_addr;
    logic       space, push, pop, q_valid;
    t_cmd       push_cmd, q_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RESET;
        end else if (i_cfg_valid) begin
            r_dev_addr <= i_cfg_device_address;
        end
    end

    clcd_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_req_type         (i_req_type),
        .i_char_code        (i_char_code),
        .i_row              (i_row),
        .i_column           (i_column),
        .i_backlight_enable (i_backlight_enable),
        .i_space            (space),
        .o_push             (push),
        .o_cmd              (push_cmd)
    );

    clcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_space (space),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    clcd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_cmd             (q_cmd),
        .o_pop             (pop),
        .i_dev_addr        (r_dev_addr),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_expander_byte   (o_expander_byte),
        .o_bus_address     (o_bus_address),
        .o_pause_before_ms (o_pause_before_ms),
        .o_pause_after_ms  (o_pause_after_ms),
        .o_error           (o_error),
        .o_last            (o_last)
    );

endmodule

@@ rtl/clcd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_front
// Accepts commands, checks them against the display state and turns each into
// one queued operation. Holds the init and backlight state.
// ----------------------------------------------------------------------------
module clcd_front
    import clcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_char_code,
    input  logic [2:0] i_row,
    input  logic [4:0] i_column,
    input  logic       i_backlight_enable,
    input  logic       i_space,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic r_init_done, n_init_done;
    logic r_bl_on, n_bl_on;
    logic bad_pos;

    assign o_ready = i_space;
    assign o_push  = i_valid & i_space;
    assign bad_pos = (i_row > MAX_ROW) || (i_column > MAX_COLUMN);

    always_comb begin
        n_init_done = r_init_done;
        n_bl_on     = r_bl_on;
        o_cmd.op    = OP_ERROR;
        o_cmd.data  = i_char_code;
        o_cmd.rs    = 1'b0;
        o_cmd.clr   = 1'b0;
        o_cmd.bl    = r_bl_on;
        if (i_req_type == REQ_INIT) begin
            o_cmd.op    = OP_INIT;
            o_cmd.bl    = 1'b1;
            n_init_done = 1'b1;
            n_bl_on     = 1'b1;
        end else if (r_init_done) begin
            case (i_req_type)
                REQ_CLEAR: begin
                    o_cmd.op   = OP_BYTE;
                    o_cmd.data = CMD_CLEAR;
                    o_cmd.clr  = 1'b1;
                end
                REQ_SETCUR: begin
                    if (!bad_pos) begin
                        o_cmd.op   = OP_BYTE;
                        o_cmd.data = CMD_DDRAM |
                                     (row_offset(i_row[1:0]) + {3'b000, i_column});
                    end
                end
                REQ_PRINT: begin
                    o_cmd.op = OP_BYTE;
                    o_cmd.rs = 1'b1;
                end
                REQ_BACKLIGHT: begin
                    o_cmd.op = OP_SINGLE;
                    o_cmd.bl = i_backlight_enable;
                    n_bl_on  = i_backlight_enable;
                end
                default: begin
                    o_cmd.op = OP_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_done <= 1'b0;
            r_bl_on     <= 1'b1;
        end else if (o_push) begin
            r_init_done <= n_init_done;
            r_bl_on     <= n_bl_on;
        end
    end

endmodule

@@ rtl/clcd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module clcd_queue
    import clcd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_space,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_space = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/clcd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_back
// Expands each queued operation into expander writes, one per cycle while the
// output is not stalled, and holds them in the output register until the transfer.
// ----------------------------------------------------------------------------
module clcd_back
    import clcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    input  logic [7:0] i_dev_addr,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_expander_byte,
    output logic [7:0] o_bus_address,
    output logic [5:0] o_pause_before_ms,
    output logic [1:0] o_pause_after_ms,
    output logic       o_error,
    output logic       o_last
);

    logic [3:0] r_nib;
    logic [1:0] r_ph;
    logic       r_valid;
    logic       adv;
    logic [3:0] nib;
    logic [7:0] w_byte;
    logic [5:0] w_pb;
    logic [1:0] w_pa;
    logic       w_last;
    logic       strobe;

    assign adv    = i_q_valid & (~r_valid | i_ready);
    assign strobe = (r_ph == 2'd1);

    always_comb begin
        nib    = r_nib[0] ? i_cmd.data[3:0] : i_cmd.data[7:4];
        w_byte = '0;
        w_pb   = '0;
        w_pa   = '0;
        w_last = 1'b1;
        case (i_cmd.op)
            OP_INIT: begin
                w_byte = {init_nibble(r_nib), 1'b1, strobe, 2'b00};
                w_pb   = (r_ph == 2'd0) ? init_pause(r_nib) : '0;
                w_pa   = (r_ph == PH_LAST && r_nib == INIT_CLEAR_NIB) ? PAUSE_CLEAR_MS : '0;
                w_last = (r_ph == PH_LAST) && (r_nib == INIT_LAST_NIB);
            end
            OP_BYTE: begin
                w_byte = {nib, i_cmd.bl, strobe, 1'b0, i_cmd.rs};
                w_last = (r_ph == PH_LAST) && r_nib[0];
                w_pa   = (w_last && i_cmd.clr) ? PAUSE_CLEAR_MS : '0;
            end
            OP_SINGLE: begin
                w_byte = {4'h0, i_cmd.bl, 3'b000};
            end
            default: begin
                w_byte = '0;
            end
        endcase
    end

    assign o_pop   = adv & w_last;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_nib   <= '0;
            r_ph    <= '0;
        end else begin
            if (adv) begin
                r_valid <= 1'b1;
                if (w_last) begin
                    r_nib <= '0;
                    r_ph  <= '0;
                end else if (r_ph == PH_LAST) begin
                    r_nib <= r_nib + 1'b1;
                    r_ph  <= '0;
                end else begin
                    r_ph <= r_ph + 1'b1;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_expander_byte   <= w_byte;
            o_bus_address     <= i_dev_addr;
            o_pause_before_ms <= w_pb;
            o_pause_after_ms  <= w_pa;
            o_error           <= (i_cmd.op == OP_ERROR);
            o_last            <= w_last;
        end
    end

endmodule
